// File: rtl/kahb_pkg.sv
// Package: types, codes and constants shared by the keep-alive monitor files.
`timescale 1ns / 1ps
package kahb_pkg;

  localparam int DATA_W        = 64;
  localparam int TIME_BITS_DEF = 64;
  localparam int MISS_W        = 8;
  localparam int OP_W          = 2;
  localparam int CFG_IDX_W     = 1;

  // Operation codes of an event beat
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
  localparam logic [OP_W-1:0] OP_PEER   = 2'd1;
  localparam logic [OP_W-1:0] OP_ECHO   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT = 1'd1;

  localparam logic [DATA_W-1:0] INTERVAL_RST   = '0;
  localparam logic [MISS_W-1:0] MISS_LIMIT_RST = 8'd3;
  localparam logic [MISS_W-1:0] MISS_MAX       = '1;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [DATA_W-1:0] now;
    logic [DATA_W-1:0] stamp;
  } event_t;

  typedef struct packed {
    logic              send_probe;
    logic [DATA_W-1:0] probe_stamp;
    logic              echo_req;
    logic [DATA_W-1:0] echo_stamp;
    logic [DATA_W-1:0] next_deadline;
    logic              dead;
  } result_t;

  typedef struct packed {
    logic [DATA_W-1:0] interval;
    logic [MISS_W-1:0] miss_limit;
  } cfg_t;

endpackage

// File: rtl/kahb_stream_if.sv
// Interface: valid/ready stream channel carrying one payload per beat.
`timescale 1ns / 1ps
interface kahb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/kahb_cfg.sv
// Configuration register file: interval and miss limit.
`timescale 1ns / 1ps
module kahb_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [kahb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kahb_pkg::DATA_W-1:0]     cfg_wdata,
  output kahb_pkg::cfg_t                  cfg
);
  import kahb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval   <= INTERVAL_RST;
      cfg.miss_limit <= MISS_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INTERVAL:   cfg.interval   <= cfg_wdata;
        CFG_MISS_LIMIT: cfg.miss_limit <= cfg_wdata[MISS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/kahb_engine.sv
// Engine: connection state and the single-pass evaluation of one event.
`timescale 1ns / 1ps
module kahb_engine #(
  parameter int TIME_BITS = kahb_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              commit,
  input  kahb_pkg::event_t  item,
  input  kahb_pkg::cfg_t    cfg,
  output kahb_pkg::result_t result
);
  import kahb_pkg::*;

  localparam logic [TIME_BITS-1:0] TIME_MASK = '1;

  logic                 started;
  logic                 awaiting_reply;
  logic [MISS_W-1:0]    miss_count;
  logic [TIME_BITS-1:0] last_probe_time;

  logic                 awaiting_next;
  logic [MISS_W-1:0]    miss_next;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] stamp_t;
  logic [TIME_BITS-1:0] ivl;
  logic                 enabled;
  logic [TIME_BITS-1:0] dl_cur;
  logic [TIME_BITS-1:0] dl_now;
  logic                 fire;
  logic                 is_peer;
  logic                 echo_hit;

  // Add without wrap: clamp to the time mask on carry out
  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? TIME_MASK : s[TIME_BITS-1:0];
  endfunction

  assign now_t   = item.now[TIME_BITS-1:0];
  assign stamp_t = item.stamp[TIME_BITS-1:0];
  assign ivl     = cfg.interval[TIME_BITS-1:0];
  assign enabled = |ivl;

  // Both candidate deadlines in parallel; pick after the fire decision
  assign dl_cur = sat_add(last_probe_time, ivl);
  assign dl_now = sat_add(now_t, ivl);

  assign fire     = (item.operation == OP_CHECK) && enabled &&
                    (!started || (now_t >= dl_cur));
  assign is_peer  = (item.operation == OP_PEER);
  assign echo_hit = (item.operation == OP_ECHO) && (stamp_t == last_probe_time);

  always_comb begin
    miss_next     = miss_count;
    awaiting_next = awaiting_reply;
    priority if (is_peer || echo_hit) begin
      miss_next     = '0;
      awaiting_next = 1'b0;
    end else if (fire) begin
      if (awaiting_reply && (miss_count != MISS_MAX)) begin
        miss_next = miss_count + 1'b1;
      end
      awaiting_next = 1'b1;
    end else begin
      miss_next     = miss_count;
    end
  end

  always_comb begin
    result.send_probe    = fire;
    result.probe_stamp   = fire ? DATA_W'(now_t) : '0;
    result.echo_req      = is_peer;
    result.echo_stamp    = is_peer ? DATA_W'(stamp_t) : '0;
    result.next_deadline = !enabled ? DATA_W'(TIME_MASK) :
                           fire     ? DATA_W'(dl_now)    : DATA_W'(dl_cur);
    result.dead          = enabled && (miss_next >= cfg.miss_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started         <= 1'b0;
      awaiting_reply  <= 1'b0;
      miss_count      <= '0;
      last_probe_time <= '0;
    end else if (commit) begin
      awaiting_reply <= awaiting_next;
      miss_count     <= miss_next;
      if (fire) begin
        started         <= 1'b1;
        last_probe_time <= now_t;
      end
    end
  end

endmodule

// File: rtl/keepalive_heartbeat_monitor.sv
// Top level: keep-alive heartbeat monitor with event and result stream channels.
`timescale 1ns / 1ps
// Usage:
//   events  (sink)   - one beat per event: time check, peer heartbeat or echo
//                      of our probe, with the current time and a timestamp.
//   results (source) - exactly one beat per event: probe and echo pulses with
//                      their stamps, the next probe deadline and the dead flag.
//   cfg_we/cfg_index/cfg_wdata - register writes (0 interval, 1 miss limit);
//                      write only while no event is in flight.
// Path: an event accepted into the input register is evaluated against the
//   connection state combinationally, and its result is captured by the
//   result register when that register is free to take it.
// Throughput: one event per cycle while results are taken; each state update
//   is one pass of two parallel saturating adds, compares and the miss counter.
// Reset: empties both pipeline registers and clears the connection state;
//   interval returns to zero (engine disabled) and miss limit to three.
// Stall: a held result keeps the input register full; the input register
//   still takes a beat while the output register waits, then events stalls.
module keepalive_heartbeat_monitor #(
  parameter int TIME_BITS = kahb_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  kahb_stream_if.sink                    events,
  kahb_stream_if.source                  results,
  input  logic                           cfg_we,
  input  logic [kahb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kahb_pkg::DATA_W-1:0]    cfg_wdata
);
  import kahb_pkg::*;

  cfg_t    cfg;
  event_t  item;
  logic    item_valid;
  result_t result;
  result_t out_beat;
  logic    out_valid;
  logic    advance;

  kahb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Advance the held event into the result register when that slot frees up
  assign advance      = item_valid && (!out_valid || results.ready);
  assign events.ready = !item_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (events.valid && events.ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      item <= events.payload;
    end
  end

  // Evaluate and commit state only when the result moves on
  kahb_engine #(
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_beat <= result;
    end
  end

  assign results.valid   = out_valid;
  assign results.payload = out_beat;

  // A fired probe never gets a deadline earlier than its own stamp
  a_deadline_after_probe: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.payload.send_probe) |->
      (results.payload.next_deadline >= results.payload.probe_stamp))
    else $error("probe deadline earlier than probe stamp");

  // One event cannot both fire a probe and echo a peer heartbeat
  a_probe_echo_exclusive: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.payload.send_probe && results.payload.echo_req))
    else $error("probe and echo in the same result");

  // An accepted beat is held in the input register on the next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (events.valid && events.ready) |=> item_valid)
    else $error("accepted beat lost from input register");

  // A beat that leaves the input register always lands in the result register
  a_drain_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced beat missing from result register");

endmodule
